// File: src/hcbd_pkg.sv
// shared types, constants and helpers for the chunked body decoder
// no dependencies; used by hcbd_step, hcbd_skid and http_chunked_body_decoder
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_SIZE_CR = 3'd1,
    PH_DATA    = 3'd2,
    PH_END     = 3'd3,
    PH_END_CR  = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  // bit 4 set when the character is a hex digit, low nibble holds its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: src/hcbd_step.sv
// next-state and result logic for one input beat of the chunked decoder
// depends on hcbd_pkg
module hcbd_step (
  input  hcbd_pkg::phase_t                 phase,
  input  logic [hcbd_pkg::SIZE_BITS-1:0]   remaining,
  input  logic [7:0]                       in_byte,
  input  logic                             first_byte,
  output hcbd_pkg::phase_t                 phase_next,
  output logic [hcbd_pkg::SIZE_BITS-1:0]   remaining_next,
  output hcbd_pkg::result_t                result
);

  localparam int SB = hcbd_pkg::SIZE_BITS;

  hcbd_pkg::phase_t ph;
  logic [SB-1:0]    rem;
  logic [4:0]       hex;

  always_comb begin
    ph  = first_byte ? hcbd_pkg::PH_SIZE : phase;
    rem = first_byte ? '0 : remaining;
    hex = hcbd_pkg::hex_digit(in_byte);

    phase_next     = ph;
    remaining_next = rem;
    result         = '0;

    case (ph)
      hcbd_pkg::PH_SIZE: begin
        if (in_byte == hcbd_pkg::CHAR_CR) begin
          phase_next = hcbd_pkg::PH_SIZE_CR;
        end else if (in_byte == hcbd_pkg::CHAR_LF) begin
          if (rem == '0) begin
            phase_next  = hcbd_pkg::PH_DONE;
            result.valid = 1'b1;
            result.kind  = hcbd_pkg::KIND_DONE;
          end else begin
            phase_next = hcbd_pkg::PH_DATA;
          end
        end else if (!hex[4] || rem[SB-1:SB-4] != 4'd0) begin
          // bad character or size would overflow
          phase_next   = hcbd_pkg::PH_ERROR;
          result.valid = 1'b1;
          result.kind  = hcbd_pkg::KIND_ERROR;
        end else begin
          remaining_next = {rem[SB-5:0], hex[3:0]};
        end
      end
      hcbd_pkg::PH_SIZE_CR: begin
        if (in_byte != hcbd_pkg::CHAR_LF) begin
          phase_next   = hcbd_pkg::PH_ERROR;
          result.valid = 1'b1;
          result.kind  = hcbd_pkg::KIND_ERROR;
        end else if (rem == '0) begin
          phase_next   = hcbd_pkg::PH_DONE;
          result.valid = 1'b1;
          result.kind  = hcbd_pkg::KIND_DONE;
        end else begin
          phase_next = hcbd_pkg::PH_DATA;
        end
      end
      hcbd_pkg::PH_DATA: begin
        remaining_next = rem - SB'(1);
        if (rem == SB'(1)) begin
          phase_next = hcbd_pkg::PH_END;
        end
        result.valid = 1'b1;
        result.kind  = hcbd_pkg::KIND_DATA;
        result.data  = in_byte;
      end
      hcbd_pkg::PH_END: begin
        if (in_byte == hcbd_pkg::CHAR_CR) begin
          phase_next = hcbd_pkg::PH_END_CR;
        end else if (in_byte == hcbd_pkg::CHAR_LF) begin
          phase_next     = hcbd_pkg::PH_SIZE;
          remaining_next = '0;
        end else begin
          phase_next   = hcbd_pkg::PH_ERROR;
          result.valid = 1'b1;
          result.kind  = hcbd_pkg::KIND_ERROR;
        end
      end
      hcbd_pkg::PH_END_CR: begin
        if (in_byte == hcbd_pkg::CHAR_LF) begin
          phase_next     = hcbd_pkg::PH_SIZE;
          remaining_next = '0;
        end else begin
          phase_next   = hcbd_pkg::PH_ERROR;
          result.valid = 1'b1;
          result.kind  = hcbd_pkg::KIND_ERROR;
        end
      end
      default: begin
        // done and error are sticky: no result
      end
    endcase
  end

endmodule

// File: src/hcbd_skid.sv
// two-entry output register with skid stage for decoder results
// depends on hcbd_pkg
module hcbd_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hcbd_pkg::result_t push_result,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        body_byte
);

  logic              main_valid;
  hcbd_pkg::result_t main_res;
  logic              skid_valid;
  hcbd_pkg::result_t skid_res;

  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_kind  = main_res.kind;
  assign body_byte = main_res.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no push possible here, drain skid into main
        if (out_ready) begin
          main_res   <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (push && push_result.valid) begin
        if (!main_valid || out_ready) begin
          main_valid <= 1'b1;
          main_res   <= push_result;
        end else begin
          skid_valid <= 1'b1;
          skid_res   <= push_result;
        end
      end else if (out_ready) begin
        main_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/http_chunked_body_decoder.sv
// http chunked transfer body decoder, top level
// depends on hcbd_pkg, hcbd_step and hcbd_skid
//
// Decodes an HTTP/1.1 chunked body, one byte per input beat. Each chunk starts
// with a hex size line ending in CRLF or a bare LF (an empty line means size
// zero), followed by that many body bytes, each passed out as a data beat, and
// then CRLF or LF. A zero-size chunk ends the message with one "complete"
// beat. A non-hex character, a CR not followed by LF, a missing line end right
// after the data, or a size wider than SIZE_BITS gives one "error" beat. Done
// and error are sticky: further bytes produce nothing until a beat arrives with
// first_byte set, which restarts decoding with that byte. Size lines produce no
// output while digits accumulate. Chunk extensions and trailers are not
// supported. Throughput is one byte per clock: the decode state (phase plus
// size counter) is updated by a single shift-add or decrement per beat, and
// results land in an output register backed by a skid stage, so input keeps
// flowing while a result waits. in_ready drops only while the skid stage holds
// a result.
module http_chunked_body_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       first_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] body_byte
);

  // decode state
  hcbd_pkg::phase_t                 phase;
  logic [hcbd_pkg::SIZE_BITS-1:0]   remaining;
  hcbd_pkg::phase_t                 phase_next;
  logic [hcbd_pkg::SIZE_BITS-1:0]   remaining_next;
  hcbd_pkg::result_t                step_result;
  logic                             accept;

  assign accept = in_valid && in_ready;

  // per-byte decode: restart, size accumulation, data count, line-end checks
  hcbd_step u_step (
    .phase          (phase),
    .remaining      (remaining),
    .in_byte        (in_byte),
    .first_byte     (first_byte),
    .phase_next     (phase_next),
    .remaining_next (remaining_next),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= hcbd_pkg::PH_SIZE;
      remaining <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      remaining <= remaining_next;
    end
  end

  // result register plus skid stage toward the consumer
  hcbd_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_result (step_result),
    .can_push    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .body_byte   (body_byte)
  );

endmodule
